/* src/rbse_pkg.sv */
// Shared types, constants and helper functions of the rational Bezier surface evaluator.
package rbse_pkg;

  localparam int MAX_ORDER       = 8;
  localparam int IDX_W           = $clog2(MAX_ORDER);
  localparam int ADDR_W          = 2 * IDX_W;
  localparam int CNT_W           = 4;
  localparam int CFG_IDX_W       = 4;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
  localparam int COORD_W         = 32;
  localparam int WEIGHT_W        = 24;
  localparam int COORD_FRAC      = 16;
  localparam int LANE_W          = 41;
  localparam int LANES           = 4;
  localparam int PROD_W          = LANE_W + PARAM_W + 2;
  localparam int HOM_W           = COORD_W + WEIGHT_W + 1;
  localparam int DIV_W           = LANE_W - 1 + COORD_FRAC;
  localparam int DIV_CNT_W       = $clog2(DIV_W + 1);

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  // Lane order of a homogeneous point.
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_WT = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
  localparam logic [CNT_W-1:0]     CFG_RESET_COUNT = CNT_W'(4);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic [IDX_W-1:0]           grid_row;
    logic [IDX_W-1:0]           grid_column;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic [WEIGHT_W-1:0]        point_weight;
    logic [PARAM_W-1:0]         param_u;
    logic [PARAM_W-1:0]         param_v;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  surface_x;
    logic signed [COORD_W-1:0]  surface_y;
    logic signed [COORD_W-1:0]  surface_z;
    logic [WEIGHT_W-1:0]        surface_weight;
    logic                       zero_weight;
  } rsp_t;

  // One stored control point.
  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [WEIGHT_W-1:0]        w;
  } point_t;

  typedef logic signed [LANE_W-1:0] lane_t;
  typedef lane_t [LANES-1:0]        hpoint_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             hom_write;
    logic [IDX_W-1:0] hom_col;
    logic             launch;
    logic             use_u;
    logic             shift;
    logic             ins;
    logic [IDX_W-1:0] ins_pos;
    logic             store_row;
    logic [IDX_W-1:0] row_idx;
    logic             copy_rows;
    logic             div_start;
    logic [1:0]       div_sel;
    logic             emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic w_zero;
    logic div_done;
  } sts_t;

  // A count of zero acts as one, a count above the grid size as the grid size.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (c > CNT_W'(MAX_ORDER)) r = CNT_W'(MAX_ORDER);
    return r;
  endfunction

  function automatic logic [PARAM_W-1:0] sat_param(input logic [PARAM_W-1:0] p);
    return (p > PARAM_ONE) ? PARAM_ONE : p;
  endfunction

endpackage

/* src/rbse_ram.sv */
// Generic single-port-write, registered-read RAM.
module rbse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/rbse_div.sv */
// Restoring divider, one quotient bit per cycle.
module rbse_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rbse_pkg::DIV_W-1:0]     dividend,
  input  logic [rbse_pkg::WEIGHT_W-1:0]  divisor,
  output logic                           done,
  output logic [rbse_pkg::DIV_W-1:0]     quotient
);
  import rbse_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WEIGHT_W-1:0]  rem;
  logic [WEIGHT_W-1:0]  dsr;
  logic [WEIGHT_W:0]    trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (running) begin
      if (trial >= {1'b0, dsr}) begin
        rem      <= WEIGHT_W'(trial - {1'b0, dsr});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[WEIGHT_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule

/* src/rbse_ctrl.sv */
// Sequencer of the surface evaluator: loads, row reductions, column reduction, divisions.
module rbse_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  rbse_pkg::op_t                   operation,
  output logic                            busy,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbse_pkg::CNT_W-1:0]      cfg_data,
  output logic                            ram_we,
  output logic [rbse_pkg::ADDR_W-1:0]     ram_raddr,
  output rbse_pkg::cmd_t                  cmd,
  input  rbse_pkg::sts_t                  sts
);
  import rbse_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_PASS  = 9'b000000100,
    S_STORE = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_FINAL = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] rows_cfg, cols_cfg, rows, cols;
  logic [CNT_W-1:0] row, col, n, k;
  logic             rd_pend, hom_pend, use_u;
  logic [IDX_W-1:0] rd_col, hom_col;
  logic [1:0]       sel;
  logic             accept, rd_issue, load_done, pass_last;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_we    = accept && (operation == OP_LOAD);
  assign ram_raddr = {row[IDX_W-1:0], col[IDX_W-1:0]};
  assign rd_issue  = (state == S_LOAD) && (col < cols);
  assign load_done = (state == S_LOAD) && (col == cols) && !rd_pend && !hom_pend;
  assign pass_last = (k == n - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && operation == OP_EVAL) state_next = S_LOAD;
      S_LOAD:  if (load_done) state_next = (cols == CNT_W'(1)) ? S_STORE : S_PASS;
      S_PASS: begin
        if (pass_last && n == CNT_W'(2)) state_next = use_u ? S_FINAL : S_STORE;
      end
      S_STORE: state_next = (CNT_W'(row + CNT_W'(1)) == rows) ? S_COPY : S_LOAD;
      S_COPY:  state_next = (rows == CNT_W'(1)) ? S_FINAL : S_PASS;
      S_FINAL: state_next = sts.w_zero ? S_EMIT : S_DIV;
      S_DIV:   state_next = S_WAIT;
      S_WAIT:  if (sts.div_done) state_next = (sel == 2'd2) ? S_EMIT : S_DIV;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.hom_write = hom_pend;
    cmd.hom_col   = hom_col;
    cmd.launch    = (state == S_PASS) && !pass_last;
    cmd.use_u     = use_u;
    cmd.shift     = (state == S_PASS);
    cmd.ins       = (state == S_PASS) && (k != '0);
    cmd.ins_pos   = IDX_W'(n - CNT_W'(2));
    cmd.store_row = (state == S_STORE);
    cmd.row_idx   = row[IDX_W-1:0];
    cmd.copy_rows = (state == S_COPY);
    cmd.div_start = (state == S_DIV);
    cmd.div_sel   = sel;
    cmd.emit      = (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rows_cfg <= CFG_RESET_COUNT;
      cols_cfg <= CFG_RESET_COUNT;
      rd_pend  <= 1'b0;
      hom_pend <= 1'b0;
      rows     <= CFG_RESET_COUNT;
      cols     <= CFG_RESET_COUNT;
      row      <= '0;
      col      <= '0;
      n        <= '0;
      k        <= '0;
      use_u    <= 1'b0;
      sel      <= '0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_issue;
      hom_pend <= rd_pend;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROWS: rows_cfg <= cfg_data;
          CFG_COLS: cols_cfg <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && operation == OP_EVAL) begin
            rows  <= clamp_count(rows_cfg);
            cols  <= clamp_count(cols_cfg);
            row   <= '0;
            col   <= '0;
            use_u <= 1'b0;
          end
        end
        S_LOAD: begin
          if (rd_issue) col <= col + CNT_W'(1);
          if (load_done) begin
            n <= cols;
            k <= '0;
          end
        end
        S_PASS: begin
          if (pass_last) begin
            n <= n - CNT_W'(1);
            k <= '0;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_STORE: begin
          row <= row + CNT_W'(1);
          col <= '0;
        end
        S_COPY: begin
          n     <= rows;
          k     <= '0;
          use_u <= 1'b1;
        end
        S_FINAL: sel <= '0;
        S_WAIT:  if (sts.div_done) sel <= sel + 2'd1;
        S_DIV, S_EMIT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_col  <= col[IDX_W-1:0];
    hom_col <= rd_col;
  end
endmodule

/* src/rbse_dp.sv */
// Datapath: homogeneous conversion, lerp lanes, work line, row results, projection.
module rbse_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rbse_pkg::cmd_t               cmd,
  output rbse_pkg::sts_t               sts,
  input  rbse_pkg::point_t             rdata,
  input  logic [rbse_pkg::PARAM_W-1:0] param_u,
  input  logic [rbse_pkg::PARAM_W-1:0] param_v,
  output logic                         result_valid,
  output rbse_pkg::rsp_t               result
);
  import rbse_pkg::*;

  logic [PARAM_W-1:0]       u_sat, v_sat, t;
  logic signed [HOM_W-1:0]  hx, hy, hz;
  logic [WEIGHT_W-1:0]      hw;
  hpoint_t                  hom_pt, lerp_res, a_reg;
  hpoint_t                  line [MAX_ORDER];
  hpoint_t                  line_sh [MAX_ORDER];
  hpoint_t                  rows_r [MAX_ORDER];
  logic signed [LANE_W:0]   diff [LANES];
  logic signed [PROD_W-1:0] prod [LANES];
  lane_t                    h_sel;
  logic                     div_neg;
  logic [DIV_W-1:0]         dividend, quo;
  logic                     div_done;
  logic [COORD_W-1:0]       sat_val;
  logic [COORD_W-1:0]       out_c [3];

  assign t = cmd.use_u ? u_sat : v_sat;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_sat <= sat_param(param_u);
      v_sat <= sat_param(param_v);
    end
    hx <= rdata.x * $signed({1'b0, rdata.w});
    hy <= rdata.y * $signed({1'b0, rdata.w});
    hz <= rdata.z * $signed({1'b0, rdata.w});
    hw <= rdata.w;
  end

  always_comb begin
    hom_pt[LANE_X]  = LANE_W'(hx >>> COORD_FRAC);
    hom_pt[LANE_Y]  = LANE_W'(hy >>> COORD_FRAC);
    hom_pt[LANE_Z]  = LANE_W'(hz >>> COORD_FRAC);
    hom_pt[LANE_WT] = LANE_W'(hw);
    for (int l = 0; l < LANES; l++) begin
      diff[l]     = (LANE_W+1)'(line[1][l]) - (LANE_W+1)'(line[0][l]);
      lerp_res[l] = LANE_W'(a_reg[l] + LANE_W'(prod[l] >>> PARAM_FRAC_BITS));
    end
    for (int j = 0; j < MAX_ORDER - 1; j++) begin
      line_sh[j] = line[j + 1];
    end
    line_sh[MAX_ORDER-1] = line[MAX_ORDER-1];
  end

  // The lerp a + (b - a) * t / ONE with the floor taken by the arithmetic shift.
  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      a_reg <= line[0];
      for (int l = 0; l < LANES; l++) begin
        prod[l] <= diff[l] * $signed({1'b0, t});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_ORDER; j++) begin
      if (cmd.hom_write && cmd.hom_col == IDX_W'(j)) begin
        line[j] <= hom_pt;
      end else if (cmd.copy_rows) begin
        line[j] <= rows_r[j];
      end else if (cmd.shift) begin
        if (cmd.ins && cmd.ins_pos == IDX_W'(j)) line[j] <= lerp_res;
        else line[j] <= line_sh[j];
      end
    end
    if (cmd.store_row) rows_r[cmd.row_idx] <= line[0];
  end

  assign sts.w_zero   = (line[0][LANE_WT] == '0);
  assign sts.div_done = div_done;

  always_comb begin
    h_sel = line[0][cmd.div_sel];
    if (h_sel[LANE_W-1]) dividend = {DIV_W'(LANE_W'(-h_sel))} << COORD_FRAC;
    else dividend = {DIV_W'(h_sel)} << COORD_FRAC;
  end

  rbse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (line[0][LANE_WT][WEIGHT_W-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    if (div_neg) begin
      sat_val = (quo > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                : 32'(32'd0 - quo[COORD_W-1:0]);
    end else begin
      sat_val = (quo > DIV_W'(33'h0_7fff_ffff)) ? 32'h7fff_ffff : quo[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) div_neg <= h_sel[LANE_W-1];
    if (div_done) out_c[cmd.div_sel] <= sat_val;
    if (cmd.emit) begin
      if (sts.w_zero) begin
        result <= '{surface_x: '0, surface_y: '0, surface_z: '0,
                    surface_weight: '0, zero_weight: 1'b1};
      end else begin
        result <= '{surface_x: out_c[LANE_X], surface_y: out_c[LANE_Y],
                    surface_z: out_c[LANE_Z],
                    surface_weight: line[0][LANE_WT][WEIGHT_W-1:0],
                    zero_weight: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
  end
endmodule

/* src/rational_bezier_surface_eval.sv */
// Top level of the rational Bezier surface evaluator.
//
//   channel   | signals                               | handshake
//   ----------+---------------------------------------+------------------------------
//   request   | start, busy, request                  | taken when start && !busy
//   result    | result_valid, result                  | one-cycle strobe, no stall
//   config    | cfg_valid, cfg_ready, cfg_index/data  | written when valid && ready
//
// A load request writes one control point into the 64-entry grid RAM in the cycle it is
// taken and leaves busy low. An evaluate request keeps busy high while the single lerp
// lane group walks the work line one segment per cycle and the bit-serial divider
// performs the three projections. A zero blended weight skips the three divisions.
// The result strobe rises in the same cycle that busy drops.
// Reset is synchronous and active high; both counts return to four, the grid RAM is not
// cleared. The result strobe cannot be stalled, so it is raised exactly once per evaluate.
module rational_bezier_surface_eval (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rbse_pkg::req_t                  request,
  output logic                            result_valid,
  output rbse_pkg::rsp_t                  result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbse_pkg::CNT_W-1:0]      cfg_data
);
  import rbse_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  point_t             wr_point, rd_point;
  logic [$bits(point_t)-1:0] ram_rdata;

  // The grid RAM is addressed by row then column.
  assign wr_point = '{x: request.point_x, y: request.point_y, z: request.point_z,
                      w: request.point_weight};
  assign rd_point = point_t'(ram_rdata);

  rbse_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_ORDER * MAX_ORDER)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({request.grid_row, request.grid_column}),
    .wdata (wr_point),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The controller walks rows, columns and reduction passes.
  rbse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_raddr (ram_raddr),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath keeps everything homogeneous until the final projection.
  rbse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .rdata        (rd_point),
    .param_u      (request.param_u),
    .param_v      (request.param_v),
    .result_valid (result_valid),
    .result       (result)
  );
endmodule

/* tb/tb_rational_bezier_surface_eval.sv */
// Self-checking testbench of the rational Bezier surface evaluator.
module tb_rational_bezier_surface_eval;
  import rbse_pkg::*;

  // A watchdog ends the run when this many cycles pass without any handshake.
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS = 150;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic result_valid;
  rsp_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;

  rational_bezier_surface_eval dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the block's state: the control grid and both counts.
  longint grid_x[MAX_ORDER][MAX_ORDER];
  longint grid_y[MAX_ORDER][MAX_ORDER];
  longint grid_z[MAX_ORDER][MAX_ORDER];
  longint grid_w[MAX_ORDER][MAX_ORDER];
  logic [CNT_W-1:0] rows_reg;
  logic [CNT_W-1:0] cols_reg;

  // Surface points still owed by the block, oldest first.
  rsp_t pending_points[$];
  int errors;
  int quiet_cycles;
  bit zero_gap_phase;

  // One row of the directed table; want is only checked when fixed is set.
  typedef struct {
    req_t rq;
    bit   fixed;
    rsp_t want;
  } row_t;
  row_t directed[$];

  // One de Casteljau step in Q1.16: floor((a*(1-t) + b*t) / 2^16), 64-bit wrap.
  function automatic longint blend(longint a, longint b, longint t);
    longint s;
    s = a * ((longint'(1) <<< PARAM_FRAC_BITS) - t) + b * t;
    return s >>> PARAM_FRAC_BITS;
  endfunction

  // Divides a homogeneous coordinate by the weight, truncating, then saturates.
  function automatic logic [COORD_W-1:0] project_coord(longint h, longint w);
    longint q;
    q = (h * 65536) / w;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[COORD_W-1:0];
  endfunction

  // Evaluates the surface at (u, v) from the shadow grid.
  function automatic rsp_t surface_point(logic [PARAM_W-1:0] pu, logic [PARAM_W-1:0] pv);
    longint line[LANES][MAX_ORDER];
    longint rows_h[LANES][MAX_ORDER];
    longint u;
    longint v;
    longint w;
    int nr;
    int nc;
    rsp_t p;
    u = (pu > PARAM_ONE) ? longint'(PARAM_ONE) : longint'(pu);
    v = (pv > PARAM_ONE) ? longint'(PARAM_ONE) : longint'(pv);
    nr = (rows_reg == 0) ? 1 : (rows_reg > MAX_ORDER) ? MAX_ORDER : int'(rows_reg);
    nc = (cols_reg == 0) ? 1 : (cols_reg > MAX_ORDER) ? MAX_ORDER : int'(cols_reg);
    for (int r = 0; r < nr; r++) begin
      // Each row goes homogeneous first: coordinates scaled by the weight.
      for (int c = 0; c < nc; c++) begin
        line[0][c] = (grid_x[r][c] * grid_w[r][c]) >>> COORD_FRAC;
        line[1][c] = (grid_y[r][c] * grid_w[r][c]) >>> COORD_FRAC;
        line[2][c] = (grid_z[r][c] * grid_w[r][c]) >>> COORD_FRAC;
        line[3][c] = grid_w[r][c];
      end
      for (int i = 1; i < nc; i++)
        for (int j = 0; j + i < nc; j++)
          for (int k = 0; k < LANES; k++) line[k][j] = blend(line[k][j], line[k][j+1], v);
      for (int k = 0; k < LANES; k++) rows_h[k][r] = line[k][0];
    end
    // The row results stay homogeneous and are reduced along u.
    for (int i = 1; i < nr; i++)
      for (int j = 0; j + i < nr; j++)
        for (int k = 0; k < LANES; k++) rows_h[k][j] = blend(rows_h[k][j], rows_h[k][j+1], u);
    w = rows_h[3][0];
    p = '0;
    if (w <= 0) begin
      p.zero_weight = 1'b1;
    end else begin
      p.surface_x = project_coord(rows_h[0][0], w);
      p.surface_y = project_coord(rows_h[1][0], w);
      p.surface_z = project_coord(rows_h[2][0], w);
      p.surface_weight = w[WEIGHT_W-1:0];
    end
    return p;
  endfunction

  // Sends one request after a random gap; start stays high across back-to-back requests.
  task automatic send_request(req_t rq);
    int gap;
    gap = zero_gap_phase ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    if (rq.operation == OP_LOAD) begin
      grid_x[rq.grid_row][rq.grid_column] = longint'(rq.point_x);
      grid_y[rq.grid_row][rq.grid_column] = longint'(rq.point_y);
      grid_z[rq.grid_row][rq.grid_column] = longint'(rq.point_z);
      grid_w[rq.grid_row][rq.grid_column] = longint'({1'b0, rq.point_weight});
    end else begin
      pending_points.push_back(surface_point(rq.param_u, rq.param_v));
    end
  endtask

  // Lets the block drain before a register write.
  task automatic drain();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // The valid line drops after each write.
  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = val;
    else if (idx == CFG_COLS) cols_reg = val;
    @(posedge clk);
  endtask

  task automatic add_row(req_t rq, bit fixed, rsp_t want);
    row_t t;
    t.rq = rq;
    t.fixed = fixed;
    t.want = want;
    directed.push_back(t);
  endtask

  function automatic req_t load_req(int r, int c, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [23:0] w);
    req_t rq;
    rq = '0;
    rq.operation = OP_LOAD;
    rq.grid_row = r[IDX_W-1:0];
    rq.grid_column = c[IDX_W-1:0];
    rq.point_x = x;
    rq.point_y = y;
    rq.point_z = z;
    rq.point_weight = w;
    return rq;
  endfunction

  function automatic req_t eval_req(logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
    req_t rq;
    rq = '0;
    rq.operation = OP_EVAL;
    rq.param_u = u;
    rq.param_v = v;
    return rq;
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PARAM_ONE;
      2: return PARAM_W'($urandom_range(32'h10001, 32'h1FFFF));
      default: return PARAM_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h7FFFFFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [23:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return 24'h0;
      default: return 24'($urandom_range(32'h4000, 32'h40000));
    endcase
  endfunction

  function automatic req_t rand_load();
    return load_req($urandom_range(0, 7), $urandom_range(0, 7), rand_coord(),
                    rand_coord(), rand_coord(), rand_weight());
  endfunction

  // Results cannot be held off, so each strobe is checked in the cycle it appears.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_points.size() == 0) begin
        $display("%0t: surface point with none expected: %p", $time, result);
        errors++;
      end else begin
        rsp_t want;
        want = pending_points.pop_front();
        if (result.surface_x !== want.surface_x) begin
          $display("%0t: surface_x expected %h actual %h", $time, want.surface_x,
                   result.surface_x);
          errors++;
        end
        if (result.surface_y !== want.surface_y) begin
          $display("%0t: surface_y expected %h actual %h", $time, want.surface_y,
                   result.surface_y);
          errors++;
        end
        if (result.surface_z !== want.surface_z) begin
          $display("%0t: surface_z expected %h actual %h", $time, want.surface_z,
                   result.surface_z);
          errors++;
        end
        if (result.surface_weight !== want.surface_weight) begin
          $display("%0t: surface_weight expected %h actual %h", $time, want.surface_weight,
                   result.surface_weight);
          errors++;
        end
        if (result.zero_weight !== want.zero_weight) begin
          $display("%0t: zero_weight expected %b actual %b", $time, want.zero_weight,
                   result.zero_weight);
          errors++;
        end
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts the count.
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rsp_t want;
    rsp_t none;
    logic [CNT_W-1:0] rows_pick;
    logic [CNT_W-1:0] cols_pick;
    req_t rq;
    errors = 0;
    quiet_cycles = 0;
    zero_gap_phase = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rows_reg = CFG_RESET_COUNT;
    cols_reg = CFG_RESET_COUNT;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The grid is never read before it is written, so every entry is filled first.
    for (int r = 0; r < MAX_ORDER; r++)
      for (int c = 0; c < MAX_ORDER; c++)
        send_request(load_req(r, c, rand_coord(), rand_coord(), rand_coord(),
                              24'($urandom_range(32'h4000, 32'h40000))));
    // A few evaluations with the counts left at their reset value of four.
    for (int i = 0; i < 4; i++) send_request(eval_req(rand_param(), rand_param()));

    // The directed part runs on a 1 x 1 grid so fixed results can be read off directly.
    drain();
    write_count(CFG_ROWS, CNT_W'(1));
    write_count(CFG_COLS, CNT_W'(1));
    none = '0;
    // Unit weight at the origin projects back to the origin.
    add_row(load_req(0, 0, 32'h0, 32'h0, 32'h0, 24'h010000), 0, none);
    want = '0;
    want.surface_weight = 24'h010000;
    add_row(eval_req('0, '0), 1, want);
    // Zero weight raises the flag and forces every field to zero.
    add_row(load_req(0, 0, 32'h00050000, 32'hFFFF0000, 32'h1, 24'h0), 0, none);
    want = '0;
    want.zero_weight = 1'b1;
    add_row(eval_req(PARAM_ONE, PARAM_ONE), 1, want);
    // Smallest weight: x = 1.0 survives, y = 0.
    add_row(load_req(0, 0, 32'h00010000, 32'h0, 32'h0, 24'h1), 0, none);
    want = '0;
    want.surface_x = 32'h00010000;
    want.surface_weight = 24'h1;
    add_row(eval_req(17'h1FFFF, 17'h1FFFF), 1, want);
    // Negative coordinate under a tiny weight rounds down before projection.
    add_row(load_req(0, 0, 32'h0, 32'hFFFFFFFF, 32'h80000000, 24'h1), 0, none);
    add_row(eval_req(17'h08000, 17'h10001), 0, none);
    // Coordinate and weight extremes.
    add_row(load_req(0, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 24'hFFFFFF), 0, none);
    add_row(eval_req(17'h1FFFF, 17'h0), 0, none);
    add_row(eval_req(17'h0FFFF, 17'h00001), 0, none);
    // Loads at the other three corners of the grid.
    add_row(load_req(7, 7, 32'h80000000, 32'h7FFFFFFF, 32'h0, 24'hFFFFFF), 0, none);
    add_row(load_req(7, 0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 24'h800000), 0, none);
    add_row(load_req(0, 7, 32'hEDCBA987, 32'h65432100, 32'hF0F0F0F0, 24'h7FFFFF), 0, none);
    add_row(eval_req(PARAM_ONE, '0), 0, none);
    foreach (directed[i]) begin
      send_request(directed[i].rq);
      if (directed[i].fixed) begin
        // The table value must agree with what was just predicted.
        if (pending_points[$] !== directed[i].want) begin
          $display("%0t: directed row %0d expected %p actual %p", $time, i,
                   directed[i].want, pending_points[$]);
          errors++;
        end
      end
    end

    // Random phases, each under its own grid size; extremes and out-of-range counts first.
    for (int ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++) begin
      drain();
      case (ph)
        0: begin rows_pick = 4'd8;  cols_pick = 4'd8;  end
        1: begin rows_pick = 4'd0;  cols_pick = 4'd15; end
        2: begin rows_pick = 4'd15; cols_pick = 4'd1;  end
        3: begin rows_pick = 4'd1;  cols_pick = 4'd8;  end
        4: begin rows_pick = 4'd2;  cols_pick = 4'd9;  end
        default: begin
          rows_pick = CNT_W'($urandom_range(0, 15));
          cols_pick = CNT_W'($urandom_range(0, 15));
        end
      endcase
      write_count(CFG_ROWS, rows_pick);
      write_count(CFG_COLS, cols_pick);
      zero_gap_phase = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 1) == 0) rq = rand_load();
        else rq = eval_req(rand_param(), rand_param());
        send_request(rq);
      end
    end

    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rbse_pkg.sv
src/rbse_ram.sv
src/rbse_div.sv
src/rbse_ctrl.sv
src/rbse_dp.sv
src/rational_bezier_surface_eval.sv
tb/tb_rational_bezier_surface_eval.sv
